### hdl/crcpd_pkg.sv
package crcpd_pkg;

  localparam int unsigned HEADER_BYTES  = 10;
  localparam int unsigned TRAILER_BYTES = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int unsigned FILL_W = 7;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned OIDX_W = 6;
  localparam int unsigned DISC_W = 32;

  localparam int unsigned FRAME_SLOTS = 2;
  localparam int unsigned SLOT_W      = 1;

  localparam int unsigned OUT_FIELDS_W = 8 + 8 + 16 + LEN_W + OIDX_W + 8 + DISC_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [7:0] {
    CFG_FIRST_MAGIC   = 8'd0,
    CFG_SECOND_MAGIC  = 8'd1,
    CFG_VERSION       = 8'd2,
    CFG_PAYLOAD_LIMIT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]        version;
    logic [7:0]        ftype;
    logic [15:0]       seq_num;
    logic [LEN_W-1:0]  frame_len;
    logic [DISC_W-1:0] discards;
  } frame_desc_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
  } queue_status_t;

endpackage

### hdl/crc32_packet_deframer.sv
// Byte-stream deframer: hunts for the two sync bytes, checks a 10-byte header
// (sync pair, version, type, 16-bit sequence, 16-bit length, two reserved
// bytes, all little endian) and a trailing CRC-32 (reflected 0xEDB88320,
// preset and inverted) over header and payload, then emits one result per
// payload byte, or one result for an empty payload, with tlast on the final
// one. The input takes one byte per cycle; it stalls only while two checked
// frames still wait for delivery, since the payload buffer has two frame
// slots. Results leave at one per cycle while the receiver is ready, via the
// queue count, read and output registers; frames do not overlap, as the
// buffer has one read port. Each failed check and each byte skipped in the sync
// hunt bumps a wrapping 32-bit discard count that travels with each result.
// Configuration writes are always ready and take effect on the next cycle.
module crc32_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [7:0]                        cfg_index_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte
  input  logic [7:0]                        s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // frame_version, frame_type, frame_sequence, payload_length, payload_index,
  // payload_byte, discard_count, zero pad
  output logic [crcpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  crcpd_pkg::queue_status_t      queue_st;
  crcpd_pkg::frame_desc_t        push_desc, head_desc;
  logic                          push, pop;
  logic                          mem_we;
  logic [crcpd_pkg::SLOT_W-1:0]  mem_slot;
  logic [IDX_W-1:0]              mem_idx;
  logic [7:0]                    mem_data;

  assign cfg_ready_o = 1'b1;

  crcpd_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .queue_i     (queue_st),
    .push_o      (push),
    .desc_o      (push_desc),
    .mem_we_o    (mem_we),
    .mem_slot_o  (mem_slot),
    .mem_idx_o   (mem_idx),
    .mem_data_o  (mem_data)
  );

  crcpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .desc_o   (head_desc),
    .status_o (queue_st)
  );

  crcpd_back #(
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_we_i    (mem_we),
    .mem_slot_i  (mem_slot),
    .mem_idx_i   (mem_idx),
    .mem_data_i  (mem_data),
    .queue_i     (queue_st),
    .desc_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### hdl/crcpd_front.sv
module crcpd_front #(
  parameter int unsigned MAX_PAYLOAD = 64,
  parameter int unsigned IDX_W       = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [7:0]                     cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_data_i,
  input  crcpd_pkg::queue_status_t       queue_i,
  output logic                           push_o,
  output crcpd_pkg::frame_desc_t         desc_o,
  output logic                           mem_we_o,
  output logic [crcpd_pkg::SLOT_W-1:0]   mem_slot_o,
  output logic [IDX_W-1:0]               mem_idx_o,
  output logic [7:0]                     mem_data_o
);

  localparam logic [crcpd_pkg::FILL_W-1:0] HDR_N =
    crcpd_pkg::FILL_W'(crcpd_pkg::HEADER_BYTES);
  localparam logic [crcpd_pkg::FILL_W-1:0] TRL_N =
    crcpd_pkg::FILL_W'(crcpd_pkg::TRAILER_BYTES);
  localparam logic [6:0] MAX_LIM = 7'(MAX_PAYLOAD);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ crcpd_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0] first_q, second_q, version_q;
  logic [6:0] limit_q;

  logic [crcpd_pkg::FILL_W-1:0] fill_q, fill_d, total_q, total_d;
  logic [31:0] crc_q, crc_d, trailer_q, trailer_d;
  logic [crcpd_pkg::DISC_W-1:0] discards_q, discards_d;
  logic [7:0] hdr_q [8];

  logic                         accept;
  logic                         hdr_we;
  logic [2:0]                   hdr_idx;
  logic                         do_resync;
  logic                         hdr_ok;
  logic [6:0]                   lim;
  logic [1:0]                   t_sel;
  logic [31:0]                  trailer_n;
  logic [31:0]                  crc_upd, crc_restart;
  logic [crcpd_pkg::FILL_W-1:0] p_next, pay_off, t_diff;

  assign in_ready_o = !queue_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 8'd0;
      second_q  <= 8'd0;
      version_q <= 8'd0;
      limit_q   <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (crcpd_pkg::cfg_reg_e'(cfg_index_i))
        crcpd_pkg::CFG_FIRST_MAGIC:   first_q   <= cfg_data_i;
        crcpd_pkg::CFG_SECOND_MAGIC:  second_q  <= cfg_data_i;
        crcpd_pkg::CFG_VERSION:       version_q <= cfg_data_i;
        crcpd_pkg::CFG_PAYLOAD_LIMIT: limit_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lim         = (limit_q > MAX_LIM) ? MAX_LIM : limit_q;
    hdr_ok      = (hdr_q[0] == first_q) && (hdr_q[1] == second_q) &&
                  (hdr_q[2] == version_q) && ({hdr_q[7], hdr_q[6]} <= {9'd0, lim});
    crc_upd     = crc_byte(crc_q, in_data_i);
    crc_restart = crc_byte(crcpd_pkg::CRC_INIT, in_data_i);
    p_next      = fill_q + 7'd1;
    pay_off     = fill_q - HDR_N;
    t_diff      = fill_q - total_q;
    t_sel       = t_diff[1:0];
    trailer_n   = trailer_q | ({24'd0, in_data_i} << {t_sel, 3'b000});

    fill_d     = fill_q;
    total_d    = total_q;
    crc_d      = crc_q;
    trailer_d  = trailer_q;
    discards_d = discards_q;
    hdr_we     = 1'b0;
    hdr_idx    = fill_q[2:0];
    mem_we_o   = 1'b0;
    push_o     = 1'b0;
    do_resync  = 1'b0;

    if (accept) begin
      if (fill_q == '0 && in_data_i != first_q) begin
        discards_d = discards_q + 32'd1;
      end else if ((fill_q == 7'd1 && in_data_i != second_q) || fill_q >= total_q) begin
        do_resync = 1'b1;
      end else begin
        fill_d = p_next;
        if (fill_q < HDR_N) begin
          hdr_we = (fill_q < 7'd8);
          crc_d  = crc_upd;
        end else if (fill_q + TRL_N < total_q) begin
          mem_we_o = 1'b1;
          crc_d    = crc_upd;
        end else begin
          trailer_d = trailer_n;
        end
        if (p_next == HDR_N) begin
          if (!hdr_ok) begin
            do_resync = 1'b1;
          end else begin
            total_d   = HDR_N + hdr_q[6][6:0] + TRL_N;
            trailer_d = 32'd0;
          end
        end else if (p_next == total_q) begin
          if (trailer_n != ~crc_q) begin
            do_resync = 1'b1;
          end else begin
            push_o    = 1'b1;
            fill_d    = '0;
            total_d   = HDR_N;
            crc_d     = crcpd_pkg::CRC_INIT;
            trailer_d = 32'd0;
          end
        end
      end

      if (do_resync) begin
        discards_d = discards_q + 32'd1;
        fill_d     = '0;
        total_d    = HDR_N;
        crc_d      = crcpd_pkg::CRC_INIT;
        trailer_d  = 32'd0;
        hdr_we     = 1'b0;
        if (in_data_i == first_q) begin
          hdr_we  = 1'b1;
          hdr_idx = 3'd0;
          crc_d   = crc_restart;
          fill_d  = 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      total_q    <= HDR_N;
      crc_q      <= crcpd_pkg::CRC_INIT;
      trailer_q  <= 32'd0;
      discards_q <= '0;
    end else begin
      fill_q     <= fill_d;
      total_q    <= total_d;
      crc_q      <= crc_d;
      trailer_q  <= trailer_d;
      discards_q <= discards_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= in_data_i;
    end
  end

  assign mem_slot_o = queue_i.wr_slot;
  assign mem_idx_o  = pay_off[IDX_W-1:0];
  assign mem_data_o = in_data_i;

  assign desc_o.version   = hdr_q[2];
  assign desc_o.ftype     = hdr_q[3];
  assign desc_o.seq_num   = {hdr_q[5], hdr_q[4]};
  assign desc_o.frame_len = hdr_q[6][6:0];
  assign desc_o.discards  = discards_q;

endmodule

### hdl/crcpd_queue.sv
module crcpd_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  crcpd_pkg::frame_desc_t   desc_i,
  input  logic                     pop_i,
  output crcpd_pkg::frame_desc_t   desc_o,
  output crcpd_pkg::queue_status_t status_o
);

  localparam logic [crcpd_pkg::SLOT_W:0] SLOTS_N =
    (crcpd_pkg::SLOT_W + 1)'(crcpd_pkg::FRAME_SLOTS);

  crcpd_pkg::frame_desc_t slot_q [crcpd_pkg::FRAME_SLOTS];

  logic [crcpd_pkg::SLOT_W-1:0] wr_q, rd_q;
  logic [crcpd_pkg::SLOT_W:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= desc_i;
    end
  end

  assign desc_o           = slot_q[rd_q];
  assign status_o.full    = (cnt_q == SLOTS_N);
  assign status_o.valid   = (cnt_q != '0);
  assign status_o.wr_slot = wr_q;
  assign status_o.rd_slot = rd_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.valid)
    else $error("frame popped from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_N)
    else $error("queue count out of range");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> status_o.valid)
    else $error("pushed frame not visible");

endmodule

### hdl/crcpd_back.sv
module crcpd_back #(
  parameter int unsigned IDX_W       = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               mem_we_i,
  input  logic [crcpd_pkg::SLOT_W-1:0]       mem_slot_i,
  input  logic [IDX_W-1:0]                   mem_idx_i,
  input  logic [7:0]                         mem_data_i,
  input  crcpd_pkg::queue_status_t           queue_i,
  input  crcpd_pkg::frame_desc_t             desc_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [crcpd_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                               out_last_o
);

  localparam int unsigned MEM_DEPTH = crcpd_pkg::FRAME_SLOTS * (2 ** IDX_W);
  localparam int unsigned PAD_W     = crcpd_pkg::OUT_DATA_W - crcpd_pkg::OUT_FIELDS_W;

  logic [7:0] mem_q [MEM_DEPTH];

  logic [crcpd_pkg::LEN_W-1:0]  k_q, count;
  logic                         issued_all_q;
  logic                         rd_valid_q, rd_last_q;
  logic [crcpd_pkg::OIDX_W-1:0] rd_idx_q;
  logic [7:0]                   rd_data_q;
  logic                         out_valid_q, out_last_q;
  logic [crcpd_pkg::OUT_DATA_W-1:0] out_data_q;

  logic advance, load_out, rd_free, issue, last_issue;
  logic [7:0] pay_byte;

  assign count      = (desc_i.frame_len == '0) ? 7'd1 : desc_i.frame_len;
  assign last_issue = (k_q + 7'd1 == count);
  assign advance    = !out_valid_q || out_ready_i;
  assign load_out   = rd_valid_q && advance;
  assign rd_free    = !rd_valid_q || load_out;
  assign issue      = queue_i.valid && !issued_all_q && rd_free;
  assign pop_o      = load_out && rd_last_q;
  assign pay_byte   = (desc_i.frame_len == '0) ? 8'd0 : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[{mem_slot_i, mem_idx_i}] <= mem_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem_q[{queue_i.rd_slot, k_q[IDX_W-1:0]}];
      rd_idx_q  <= k_q[crcpd_pkg::OIDX_W-1:0];
      rd_last_q <= last_issue;
    end
    if (load_out) begin
      out_data_q <= {{PAD_W{1'b0}}, desc_i.discards, pay_byte, rd_idx_q,
                     desc_i.frame_len, desc_i.seq_num, desc_i.ftype, desc_i.version};
      out_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q          <= '0;
      issued_all_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (issue) begin
        k_q <= last_issue ? '0 : k_q + 7'd1;
      end
      if (issue && last_issue) begin
        issued_all_q <= 1'b1;
      end else if (pop_o) begin
        issued_all_q <= 1'b0;
      end
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (load_out) begin
        rd_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
